### sv/malt_pkg.sv
// ----------------------------------------------------------------------------
// malt_pkg
// shared types and constants for the mac address learning table
// ----------------------------------------------------------------------------
package malt_pkg;

    localparam int ADDR_W   = 48;
    localparam int CALL_W   = 64;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;

    // stream word widths, padded to whole bytes
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [STATUS_W-1:0] {
        ST_PRESENT   = 2'd0,
        ST_ADDED     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        MODE_LEARN  = 1'b0,
        MODE_LOOKUP = 1'b1
    } t_mode;

    // preset group entries held from reset
    localparam int PRESET_COUNT = 3;

    localparam logic [ADDR_W-1:0] ADDR_BROADCAST = 48'hFFFF_FFFF_FFFF;
    localparam logic [ADDR_W-1:0] ADDR_ALL_HOSTS = 48'h0100_5E00_0001;
    localparam logic [ADDR_W-1:0] ADDR_DX_CLUSTER = 48'h0100_5E00_0023;

    localparam logic [CALL_W-1:0] CALL_SPACES = 64'h2020_2020_2020_2020;
    localparam logic [CALL_W-1:0] CALL_CQ     = 64'h4351_4351_4351_2020;

    function automatic logic [ADDR_W-1:0] preset_addr(input int idx);
        case (idx)
            0:       preset_addr = ADDR_BROADCAST;
            1:       preset_addr = ADDR_ALL_HOSTS;
            default: preset_addr = ADDR_DX_CLUSTER;
        endcase
    endfunction

    function automatic logic [CALL_W-1:0] preset_call(input int idx);
        case (idx)
            0:       preset_call = CALL_SPACES;
            default: preset_call = CALL_CQ;
        endcase
    endfunction

endpackage

### sv/mac_address_learning_table.sv
// ----------------------------------------------------------------------------
// mac_address_learning_table
// associative table from ethernet addresses to packed 8-character callsigns
// ----------------------------------------------------------------------------
// Each input word is one table access. A word is first captured in an input
// register; every slot is then compared against its address at once, and the
// result word is loaded into the output register together with any table
// write. One word is accepted per clock as long as the output side keeps
// taking results, so the sustained rate is one word per cycle. In learn mode
// an absent address is stored with its callsign in the lowest free slot
// (status added), a present one reports its slot and stored callsign (status
// present), and a full table drops it (status full). In lookup mode the
// stored callsign is returned, or status not found. When several slots match
// the lowest one wins. After reset slots 0 to 2 hold the broadcast address,
// the all-hosts multicast address and the dx-cluster multicast address; all
// other slots are free.
// ----------------------------------------------------------------------------
module mac_address_learning_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [47:0] mac_address, [111:48] station_callsign
    input  logic [malt_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // [0] mode
    input  logic                             i_s_axis_tuser,
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [5:0] slot_index, [69:6] found_callsign, [71:70] zero
    output logic [malt_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // [1:0] status
    output logic [malt_pkg::STATUS_W-1:0]    o_m_axis_tuser
);
    import malt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // input register
    logic               r_in_valid;
    t_mode              r_in_mode;
    logic [ADDR_W-1:0]  r_in_addr;
    logic [CALL_W-1:0]  r_in_call;

    // table storage, one compare per slot
    logic [TABLE_ENTRIES-1:0] r_slot_valid;
    logic [ADDR_W-1:0]        r_slot_addr [TABLE_ENTRIES];
    logic [CALL_W-1:0]        r_slot_call [TABLE_ENTRIES];

    // output register
    logic               r_out_valid;
    t_status            r_out_status;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [CALL_W-1:0]  r_out_call;

    // search results
    logic [TABLE_ENTRIES-1:0] w_hit;
    logic [TABLE_ENTRIES-1:0] w_hit_1h;
    logic [TABLE_ENTRIES-1:0] w_free;
    logic [IDX_W-1:0]         w_hit_idx;
    logic [IDX_W-1:0]         w_free_idx;
    logic [CALL_W-1:0]        w_hit_call;
    logic                     w_any_hit;
    logic                     w_any_free;
    logic                     w_advance;
    logic                     w_write;

    t_status            n_status;
    logic [SLOT_W-1:0]  n_slot;
    logic [CALL_W-1:0]  n_call;

    // the output register frees up when it is empty or being taken
    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_advance;

    // parallel address compare against every valid slot
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_hit[i] = r_slot_valid[i] && (r_slot_addr[i] == r_in_addr);
        end
    end

    assign w_free     = ~r_slot_valid;
    assign w_any_hit  = |w_hit;
    assign w_any_free = |w_free;
    // isolate the lowest matching slot
    assign w_hit_1h   = w_hit & (~w_hit + TABLE_ENTRIES'(1));

    // lowest-index priority encoders: scan down so the lowest set bit wins
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_hit_idx = IDX_W'(i);
            end
            if (w_free[i]) begin
                w_free_idx = IDX_W'(i);
            end
        end
    end

    // and-or readout of the winning slot's callsign
    always_comb begin
        w_hit_call = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_hit_call = w_hit_call | (r_slot_call[i] & {CALL_W{w_hit_1h[i]}});
        end
    end

    // result word and table write decision
    always_comb begin
        n_status = ST_NOT_FOUND;
        n_slot   = '0;
        n_call   = '0;
        w_write  = 1'b0;
        if (w_any_hit) begin
            n_status = ST_PRESENT;
            n_slot   = SLOT_W'(w_hit_idx);
            n_call   = w_hit_call;
        end else if (r_in_mode == MODE_LOOKUP) begin
            n_status = ST_NOT_FOUND;
        end else if (w_any_free) begin
            n_status = ST_ADDED;
            n_slot   = SLOT_W'(w_free_idx);
            w_write  = r_in_valid && w_advance;
        end else begin
            n_status = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            // preset slots valid, all others free
            r_slot_valid <= TABLE_ENTRIES'((1 << PRESET_COUNT) - 1);
            for (int i = 0; i < PRESET_COUNT; i++) begin
                r_slot_addr[i]  <= preset_addr(i);
                r_slot_call[i]  <= preset_call(i);
            end
        end else begin
            // input capture
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r_in_valid <= 1'b1;
                r_in_mode  <= t_mode'(i_s_axis_tuser);
                r_in_addr  <= i_s_axis_tdata[ADDR_W-1:0];
                r_in_call  <= i_s_axis_tdata[ADDR_W+CALL_W-1:ADDR_W];
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            // result capture
            if (w_advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_out_status <= n_status;
                    r_out_slot   <= n_slot;
                    r_out_call   <= n_call;
                end
            end

            // learn into the lowest free slot
            if (w_write) begin
                r_slot_valid[w_free_idx] <= 1'b1;
                r_slot_addr[w_free_idx]  <= r_in_addr;
                r_slot_call[w_free_idx]  <= r_in_call;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {(OUT_DATA_W - SLOT_W - CALL_W)'(0), r_out_call, r_out_slot};

endmodule
